// ===== design/liu_pkg.sv =====
// Shared types and constants for the linear interpolation upsampler.
package liu_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FACTOR_BITS = 5;
   localparam logic [FACTOR_BITS-1:0] UP_FACTOR_RESET = FACTOR_BITS'(3);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          stream_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          last;
   } rsp_type;

endpackage

// ===== design/liu_divider.sv =====
// Restoring divider, one quotient bit per cycle, SAMPLE_BITS-bit quotient.
module liu_divider #(
   parameter int DIVIDEND_BITS = 23,
   parameter int DIVISOR_BITS  = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DIVIDEND_BITS-1:0]            dividend,
   input  logic [DIVISOR_BITS-1:0]             divisor,
   output logic                                done,
   output logic [liu_pkg::SAMPLE_BITS-1:0]     quotient
);
   import liu_pkg::*;

   localparam int CW = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

   logic [DIVIDEND_BITS-1:0] rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] dsh_ff, dsh_in;
   logic [SAMPLE_BITS-1:0]   quo_ff, quo_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     fits;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      fits    = (rem_ff >= dsh_ff);
      if (start) begin
         rem_in  = dividend;
         dsh_in  = DIVIDEND_BITS'(divisor) << (SAMPLE_BITS - 1);
         cnt_in  = CW'(SAMPLE_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[SAMPLE_BITS-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // no restart while a division runs
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   // last iteration raises done next cycle
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> done_ff) else $error("done missing");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");

endmodule

// ===== design/linear_interp_upsampler.sv =====
// Top level: linear interpolation upsampler, mono in, duplicated stereo out.
// Each result passes through the PREP, DIVIDE and PUBLISH states to the output register; PUBLISH
// waits while that register is full. Items are taken only in IDLE, so a new item waits until all F
// results of the last item (F = saturated factor), all from the single serial divider, are out.
// Synchronous active-high reset: factor 3, previous sample 0, no sample seen.
module linear_interp_upsampler #(
   parameter int MAX_FACTOR = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  liu_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output liu_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [liu_pkg::FACTOR_BITS-1:0]      csr_data
);
   import liu_pkg::*;

   // f fits 0..MAX_FACTOR; accumulator holds (F-k)*a + k*b with sign
   localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR + 1) : 1;
   localparam int NW = SAMPLE_BITS + FW + 1;
   localparam int DW = NW + 1;
   localparam int DV = FW + 1;

   typedef enum logic [1:0] {
      IDLE,
      PREP,
      DIVIDE,
      PUBLISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [FACTOR_BITS-1:0]        up_factor_ff, up_factor_in;
   logic signed [SAMPLE_BITS-1:0] prev_sample_ff, prev_sample_in;
   logic                          have_prev_ff, have_prev_in;
   logic [FW-1:0]                 f_ff, f_in;
   logic [FW-1:0]                 k_ff, k_in;
   logic signed [NW-1:0]          num_ff, num_in;
   logic signed [SAMPLE_BITS:0]   diff_ff, diff_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_payload_ff, rsp_payload_in;

   logic [FW-1:0]                 f_sat;
   logic [NW-1:0]                 mag;
   logic [DW-1:0]                 dividend;
   logic [DV-1:0]                 divisor;
   logic                          div_start;
   logic                          div_done;
   logic [SAMPLE_BITS-1:0]        quotient;
   logic [SAMPLE_BITS-1:0]        result;
   logic                          is_last;
   logic                          req_fire;
   logic                          rsp_fire;

   assign req_ready = (state_ff == IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // factors above the maximum saturate
   always_comb begin
      if (int'(up_factor_ff) > MAX_FACTOR) begin
         f_sat = FW'(MAX_FACTOR);
      end else begin
         f_sat = FW'(up_factor_ff);
      end
   end

   // rounding half away from zero: q = (2|num| + F) / 2F, sign put back after
   assign mag      = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   assign dividend = {mag, 1'b0} + DW'(f_ff);
   assign divisor  = {f_ff, 1'b0};
   assign result   = neg_ff ? (~quotient + SAMPLE_BITS'(1)) : quotient;
   assign is_last  = (k_ff == f_ff - FW'(1));
   assign div_start = (state_ff == PREP);

   liu_divider #(
      .DIVIDEND_BITS (DW),
      .DIVISOR_BITS  (DV)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in       = state_ff;
      up_factor_in   = up_factor_ff;
      prev_sample_in = prev_sample_ff;
      have_prev_in   = have_prev_ff;
      f_in           = f_ff;
      k_in           = k_ff;
      num_in         = num_ff;
      diff_in        = diff_ff;
      neg_in         = neg_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_fire ? 1'b0 : rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         up_factor_in = csr_data;
      end

      case (state_ff)
         IDLE: begin
            if (req_fire) begin
               // every item becomes the new previous sample
               prev_sample_in = req_payload.sample;
               have_prev_in   = 1'b1;
               if (!req_payload.stream_start && have_prev_ff && f_sat != '0) begin
                  f_in     = f_sat;
                  k_in     = '0;
                  num_in   = NW'($signed({1'b0, f_sat})) * NW'(prev_sample_ff);
                  diff_in  = $signed({req_payload.sample[SAMPLE_BITS-1],
                                      req_payload.sample})
                           - $signed({prev_sample_ff[SAMPLE_BITS-1], prev_sample_ff});
                  state_in = PREP;
               end
            end
         end
         PREP: begin
            neg_in   = num_ff[NW-1];
            state_in = DIVIDE;
         end
         DIVIDE: begin
            if (div_done) begin
               state_in = PUBLISH;
            end
         end
         PUBLISH: begin
            // the quotient holds in the divider until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_payload_in.left_sample  = result;
               rsp_payload_in.right_sample = result;
               rsp_payload_in.last         = is_last;
               rsp_valid_in                = 1'b1;
               if (is_last) begin
                  state_in = IDLE;
               end else begin
                  num_in   = num_ff + NW'(diff_ff);
                  k_in     = k_ff + FW'(1);
                  state_in = PREP;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         up_factor_ff   <= UP_FACTOR_RESET;
         prev_sample_ff <= '0;
         have_prev_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         up_factor_ff   <= up_factor_in;
         prev_sample_ff <= prev_sample_in;
         have_prev_ff   <= have_prev_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      f_ff           <= f_in;
      k_ff           <= k_in;
      num_ff         <= num_in;
      diff_ff        <= diff_in;
      neg_ff         <= neg_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // result index stays inside the run while a run is in progress
   a_k_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> (k_ff < f_ff)) else $error("result index past run");
   // both channels always carry the same value
   a_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.left_sample == rsp_payload_ff.right_sample))
      else $error("left and right differ");
   // divider only finishes while the sequencer waits on it
   a_done_when_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == DIVIDE)) else $error("unexpected divider done");
   // a run starts at the first result
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && state_in == PREP) |=> (k_ff == '0))
      else $error("run did not start at index zero");

endmodule
